[sv/b64se_pkg.sv]
// shared types, constants and the character table of the base64 stream encoder
// used by b64se_front, b64se_queue, b64se_back and base64_stream_encoder_unit
`default_nettype none

package b64se_pkg;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // character constants
  localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
  localparam logic [6:0] CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [6:0] CHAR_DIGIT = 7'h30;  // '0'
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH = 7'h2F;  // '/'
  localparam logic [5:0] IDX_MASK   = 6'h3F;

  // group positions
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  // one output slot: a 6-bit index or a pad
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } slot_t;

  // the characters caused by one input byte
  typedef struct packed {
    slot_t [3:0] slots;
    logic  [1:0] last_pos;  // position of the final slot in use
    logic        fin;       // job ends the message
  } job_t;

  // standard alphabet lookup
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] ix;
    ix = {1'b0, idx};
    if (idx < 6'd26) begin
      return CHAR_UPPER + ix;
    end else if (idx < 6'd52) begin
      return CHAR_LOWER + ix - 7'd26;
    end else if (idx < 6'd62) begin
      return CHAR_DIGIT + ix - 7'd52;
    end else if (idx == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

[sv/b64se_front.sv]
// front part: takes raw bytes, tracks group position and leftover bits,
// and turns each byte into a job of slots; depends on b64se_pkg
`default_nettype none

module b64se_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output b64se_pkg::job_t        q_job
);

  b64se_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        carry_r, carry_nxt;
  logic              accept;

  // transfer handshake
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // classify the byte and build its job
  always_comb begin
    q_job     = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    q_job.fin = in_last_byte;
    case (phase_r)
      b64se_pkg::PH_SECOND: begin
        q_job.slots[0].idx = {carry_r[1:0], in_data_byte[7:4]};
        if (in_last_byte) begin
          q_job.slots[1].idx = {in_data_byte[3:0], 2'b00};
          q_job.slots[2].pad = 1'b1;
          q_job.last_pos     = 2'd2;
        end else begin
          q_job.last_pos = 2'd0;
          carry_nxt      = in_data_byte[3:0];
          phase_nxt      = b64se_pkg::PH_THIRD;
        end
      end
      b64se_pkg::PH_THIRD: begin
        q_job.slots[0].idx = {carry_r, in_data_byte[7:6]};
        q_job.slots[1].idx = in_data_byte[5:0] & b64se_pkg::IDX_MASK;
        q_job.last_pos     = 2'd1;
        carry_nxt          = 4'd0;
        phase_nxt          = b64se_pkg::PH_FIRST;
      end
      default: begin
        // first position, and the unused code treated alike
        q_job.slots[0].idx = in_data_byte[7:2];
        if (in_last_byte) begin
          q_job.slots[1].idx = {in_data_byte[1:0], 4'd0};
          q_job.slots[2].pad = 1'b1;
          q_job.slots[3].pad = 1'b1;
          q_job.last_pos     = 2'd3;
        end else begin
          q_job.last_pos = 2'd0;
          carry_nxt      = {2'b00, in_data_byte[1:0]};
          phase_nxt      = b64se_pkg::PH_SECOND;
        end
      end
    endcase
    // end of message starts a fresh group
    if (in_last_byte) begin
      carry_nxt = 4'd0;
      phase_nxt = b64se_pkg::PH_FIRST;
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64se_pkg::PH_FIRST;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/b64se_queue.sv]
// short job queue between front and back, flip-flop storage
// depends on b64se_pkg
`default_nettype none

module b64se_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b64se_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output b64se_pkg::job_t      q_job
);

  b64se_pkg::job_t                   entries_r [b64se_pkg::Q_DEPTH];
  logic [b64se_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [b64se_pkg::Q_CNT_W-1:0]     count_r;
  logic                              do_push, do_pop;

  localparam logic [b64se_pkg::Q_PTR_W-1:0] PTR_LAST =
    b64se_pkg::Q_PTR_W'(b64se_pkg::Q_DEPTH - 1);
  localparam logic [b64se_pkg::Q_CNT_W-1:0] CNT_FULL =
    b64se_pkg::Q_CNT_W'(b64se_pkg::Q_DEPTH);

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_job   = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue fill count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into full queue");
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

[sv/b64se_back.sv]
// back part: walks the slots of each job, one character per cycle while out_stall
// is low, into the output register; depends on b64se_pkg
`default_nettype none

module b64se_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire b64se_pkg::job_t   q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [6:0]             out_char,
  output logic                   out_last_char
);

  b64se_pkg::job_t   cur_r;
  logic              cur_valid_r;
  logic [1:0]        pos_r;
  logic              out_valid_r;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              load_out, done, cur_free;
  b64se_pkg::slot_t  slot;

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  // stepping through the current job
  assign load_out = cur_valid_r && (!out_valid_r || !out_stall);
  assign done     = load_out && (pos_r == cur_r.last_pos);
  assign cur_free = !cur_valid_r || done;
  assign q_pop    = cur_free && q_valid;

  // character of the current slot
  always_comb begin
    slot         = cur_r.slots[pos_r];
    out_char_nxt = slot.pad ? b64se_pkg::PAD_CHAR : b64se_pkg::b64_char(slot.idx);
    out_last_nxt = cur_r.fin && (pos_r == cur_r.last_pos);
  end

  // job register and slot position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      pos_r       <= 2'd0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (load_out) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (pos_r <= cur_r.last_pos)) else $error("slot position past job end");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!cur_valid_r || done)) else $error("job popped while current one busy");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r) else $error("loaded character not presented");

endmodule

`default_nettype wire

[sv/base64_stream_encoder_unit.sv]
// top level of the streaming base64 encoder: front, job queue and back
// depends on b64se_pkg, b64se_front, b64se_queue, b64se_back
//
//   channel | direction | ports                                   | handshake
//   input   | in        | in_data_byte[7:0], in_last_byte         | in_valid / in_stall
//   result  | out       | out_char[6:0], out_last_char            | out_valid / out_stall
//
// one character leaves per cycle while out_stall is low, set by the single-character
// output register of the back part; a byte gives one or two characters, a final
// byte up to four. a byte is accepted whenever the two-entry job queue has room,
// also while a character waits on out_stall. the first character of a byte passes
// the job queue, the job register and the output register before it appears.
// reset (rst_n, synchronous) empties the queue and starts a new group.
`default_nettype none

module base64_stream_encoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_char,
  output logic            out_last_char
);

  b64se_pkg::job_t push_job, q_job;
  logic            q_full, q_push, q_valid, q_pop;

  // byte classification
  b64se_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // job queue
  b64se_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // character output
  b64se_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

[tb/base64_stream_encoder_unit_tb.sv]
// self-checking testbench of base64_stream_encoder_unit: directed and random messages
// depends on b64se_pkg (phase_t, PAD_CHAR) and the encoder top level
`timescale 1ns / 100ps

module base64_stream_encoder_unit_tb;

  // one raw byte of a message, one encoded character
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } b64_char_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RANDOM_BYTES = 90;
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       out_last_char;

  raw_byte_t raw_bytes[$];
  b64_char_t char_expect[$];

  // encoder state as seen by the predictor
  b64se_pkg::phase_t group_pos = b64se_pkg::PH_FIRST;
  logic [3:0]        carry = 4'h0;

  bit took_input = 1'b0;
  int failures = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int chars_checked = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int stall_left = 0;

  base64_stream_encoder_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last_char(out_last_char)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  // standard alphabet, leftmost character is index 0
  function automatic logic [6:0] alpha_char(input logic [5:0] idx);
    int pos;
    pos = 8 * (63 - int'(idx));
    return ALPHABET[pos +: 7];
  endfunction

  task automatic push_char(input logic [6:0] ch, input logic fin);
    b64_char_t c;
    c.ch = ch;
    c.fin = fin;
    char_expect.push_back(c);
  endtask

  // expected characters for one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (group_pos)
      b64se_pkg::PH_SECOND: begin
        push_char(alpha_char({carry[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(alpha_char({b[3:0], 2'b00}), 1'b0);
          push_char(b64se_pkg::PAD_CHAR, 1'b1);
        end else begin
          carry = b[3:0];
          group_pos = b64se_pkg::PH_THIRD;
        end
      end
      b64se_pkg::PH_THIRD: begin
        push_char(alpha_char({carry, b[7:6]}), 1'b0);
        push_char(alpha_char(b[5:0]), fin);
        carry = 4'h0;
        group_pos = b64se_pkg::PH_FIRST;
      end
      // first position, and the unused one treated as first
      default: begin
        push_char(alpha_char(b[7:2]), 1'b0);
        if (fin) begin
          push_char(alpha_char({b[1:0], 4'h0}), 1'b0);
          push_char(b64se_pkg::PAD_CHAR, 1'b0);
          push_char(b64se_pkg::PAD_CHAR, 1'b1);
        end else begin
          carry = {2'b00, b[1:0]};
          group_pos = b64se_pkg::PH_SECOND;
        end
      end
    endcase
    // end of message starts a new group
    if (fin) begin
      carry = 4'h0;
      group_pos = b64se_pkg::PH_FIRST;
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic fin);
    raw_byte_t r;
    r.data = data;
    r.fin = fin;
    raw_bytes.push_back(r);
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    logic v_next;
    raw_byte_t nxt;
    v_next = in_valid;
    if (in_valid && took_input) begin
      v_next = 1'b0;
    end
    if (!v_next && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (raw_bytes.size() > 0) begin
        nxt = raw_bytes.pop_front();
        in_data_byte <= nxt.data;
        in_last_byte <= nxt.fin;
        v_next = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          // long stretch with no idling
          burst_left = $urandom_range(20, 40);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
    in_valid <= v_next;
  end

  // receiver: stall pattern drawn at random from three modes: never, sometimes, mostly stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin
    b64_char_t want;
    took_input = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        took_input = 1'b1;
        encode_byte(in_data_byte, in_last_byte);
        bytes_sent++;
        if (in_last_byte) begin
          messages_sent++;
        end
      end
      if (out_valid && !out_stall) begin
        if (char_expect.size() == 0) begin
          $error("unexpected character: out_char actual 0x%02h, out_last_char actual %0b",
                 out_char, out_last_char);
          failures++;
        end else begin
          want = char_expect.pop_front();
          chars_checked++;
          if (out_char !== want.ch) begin
            $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, out_char);
            failures++;
          end
          if (out_last_char !== want.fin) begin
            $error("out_last_char: expected %0b, actual %0b", want.fin, out_last_char);
            failures++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int len;
    int total;
    logic [7:0] data;

    // directed: final byte at each group position, extremes, '+' and '/'
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hBF, 1'b1);
    repeat (3) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    repeat (4) queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);

    // random messages, mostly short
    total = 0;
    while (total < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(10, 20);
      end else begin
        len = $urandom_range(1, 9);
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom_range(0, 255));
        endcase
        queue_byte(data, i == len - 1);
      end
      total += len;
    end

    while (raw_bytes.size() > 0 || in_valid) @(posedge clk);
    while (char_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages, %0d bytes, %0d characters compared",
             messages_sent, bytes_sent, chars_checked);
    $display("final byte seen at every group position, with random sender gaps and stalls");
    if (failures == 0 && char_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("timeout with %0d characters outstanding", char_expect.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
sv/b64se_pkg.sv
sv/b64se_front.sv
sv/b64se_queue.sv
sv/b64se_back.sv
sv/base64_stream_encoder_unit.sv
tb/base64_stream_encoder_unit_tb.sv
